FILE: rtl/dfu_pkg.sv
// Package for the DFU download sequencer: state and status codes, item and
// result structs, flash status bit positions and default parameters.
// Depends on nothing; the files that use it refer to it by scoped names.
package dfu_pkg;

	localparam int TRANSFER_BYTES_DEF = 1024;
	// Sector size must be a power of two (1024, 2048 or 4096)
	localparam int SECTOR_BYTES_DEF   = 2048;
	localparam int WORD_BYTES_DEF     = 4;

	localparam int ADDR_W = 24;

	localparam logic [9:0] TIMEOUT_RESET    = 10'd1;
	localparam logic [9:0] TIMEOUT_MANIFEST = 10'd1000;

	localparam int FS_COMPLETE  = 7;
	localparam int FS_COLLISION = 6;
	localparam int FS_ACCESS    = 5;
	localparam int FS_PROTECT   = 4;
	localparam int FS_CMD_ERR   = 0;

	typedef enum logic [1:0] {
		OP_DNLOAD    = 2'd0,
		OP_GETSTATUS = 2'd1,
		OP_CLRSTATUS = 2'd2,
		OP_ABORT     = 2'd3
	} op_t;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DNSYNC   = 7'b0000010,
		ST_BUSY     = 7'b0000100,
		ST_DNIDLE   = 7'b0001000,
		ST_MANSYNC  = 7'b0010000,
		ST_MANIFEST = 7'b0100000,
		ST_ERROR    = 7'b1000000
	} proto_t;

	typedef enum logic [2:0] {
		PC_IDLE     = 3'd0,
		PC_DNSYNC   = 3'd1,
		PC_BUSY     = 3'd2,
		PC_DNIDLE   = 3'd3,
		PC_MANSYNC  = 3'd4,
		PC_MANIFEST = 3'd5,
		PC_ERROR    = 3'd6,
		PC_UNUSED   = 3'd7
	} proto_code_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_ERASE   = 3'b010,
		PH_PROGRAM = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		SC_OK      = 3'd0,
		SC_ADDRESS = 3'd1,
		SC_STALLED = 3'd2,
		SC_UNKNOWN = 3'd3,
		SC_ERASE   = 3'd4,
		SC_VERIFY  = 3'd5,
		SC_RSVD6   = 3'd6,
		SC_RSVD7   = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_ERASE   = 2'd1,
		CMD_PROGRAM = 2'd2,
		CMD_RSVD    = 2'd3
	} cmd_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] block_length;
		logic [15:0] packet_offset;
		logic [15:0] packet_length;
		logic [7:0]  flash_status;
	} item_t;

	typedef struct packed {
		proto_t            proto;
		status_t           status;
		logic [9:0]        timeout;
		phase_t            phase;
		logic [ADDR_W-1:0] addr;
	} state_t;

	typedef struct packed {
		logic              accepted;
		status_t           request_status;
		logic [9:0]        poll_timeout;
		proto_code_t       protocol_state;
		cmd_t              flash_command;
		logic [ADDR_W-1:0] flash_address;
		logic [15:0]       flash_word_count;
	} result_t;

	function automatic proto_code_t proto_code(input proto_t p);
		proto_code_t c;
		case (p)
			ST_IDLE:     c = PC_IDLE;
			ST_DNSYNC:   c = PC_DNSYNC;
			ST_BUSY:     c = PC_BUSY;
			ST_DNIDLE:   c = PC_DNIDLE;
			ST_MANSYNC:  c = PC_MANSYNC;
			ST_MANIFEST: c = PC_MANIFEST;
			ST_ERROR:    c = PC_ERROR;
			default:     c = PC_UNUSED;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/dfu_if.sv
// Request and result channel interfaces of the DFU download sequencer.
// Valid/ready handshake with the payload fields; no package dependency.
interface dfu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] block_number;
	logic [15:0] block_length;
	logic [15:0] packet_offset;
	logic [15:0] packet_length;
	logic [7:0]  flash_status;

	modport source (
		output valid, op, block_number, block_length, packet_offset, packet_length,
		flash_status,
		input  ready
	);
	modport sink (
		input  valid, op, block_number, block_length, packet_offset, packet_length,
		flash_status,
		output ready
	);
endinterface

interface dfu_rsp_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  request_status;
	logic [9:0]  poll_timeout;
	logic [2:0]  protocol_state;
	logic [1:0]  flash_command;
	logic [23:0] flash_address;
	logic [15:0] flash_word_count;

	modport source (
		output valid, accepted, request_status, poll_timeout, protocol_state,
		flash_command, flash_address, flash_word_count,
		input  ready
	);
	modport sink (
		input  valid, accepted, request_status, poll_timeout, protocol_state,
		flash_command, flash_address, flash_word_count,
		output ready
	);
endinterface

FILE: rtl/dfu_step.sv
// Next-state and result logic for one request of the DFU sequencer.
// Purely combinational; uses dfu_pkg types and codes.
module dfu_step #(
	parameter int TRANSFER_BYTES = dfu_pkg::TRANSFER_BYTES_DEF,
	parameter int SECTOR_BYTES   = dfu_pkg::SECTOR_BYTES_DEF,
	parameter int WORD_BYTES     = dfu_pkg::WORD_BYTES_DEF
) (
	input  dfu_pkg::state_t              cur,
	input  dfu_pkg::item_t               item,
	input  logic [dfu_pkg::ADDR_W-1:0]   target_addr,
	output dfu_pkg::state_t              nxt,
	output dfu_pkg::result_t             res
);

	localparam int         SB_BITS   = $clog2(SECTOR_BYTES);
	localparam logic [15:0] WORDS    = 16'(TRANSFER_BYTES / WORD_BYTES);
	localparam logic [16:0] XFER_LIM = 17'(TRANSFER_BYTES);

	logic [16:0] pkt_end;
	logic [16:0] blen_x;

	assign pkt_end = {1'b0, item.packet_offset} + {1'b0, item.packet_length};
	assign blen_x  = {1'b0, item.block_length};

	always_comb begin
		logic             ok;
		logic             err;
		dfu_pkg::status_t err_code;
		logic [7:0]       fs;

		fs       = item.flash_status;
		ok       = 1'b1;
		err      = 1'b0;
		err_code = dfu_pkg::SC_OK;
		nxt      = cur;
		res.flash_command    = dfu_pkg::CMD_NONE;
		res.flash_address    = '0;
		res.flash_word_count = '0;

		case (item.op)
			dfu_pkg::OP_DNLOAD: begin
				if (pkt_end > XFER_LIM || pkt_end > blen_x) begin
					nxt.proto  = dfu_pkg::ST_ERROR;
					nxt.status = dfu_pkg::SC_ADDRESS;
					ok         = 1'b0;
				end else if (pkt_end != blen_x) begin
					ok = 1'b1;
				end else if (cur.proto != dfu_pkg::ST_IDLE && cur.proto != dfu_pkg::ST_DNIDLE) begin
					nxt.proto  = dfu_pkg::ST_ERROR;
					nxt.status = dfu_pkg::SC_STALLED;
					ok         = 1'b0;
				end else if (!fs[dfu_pkg::FS_COMPLETE] || cur.phase != dfu_pkg::PH_IDLE) begin
					nxt.proto  = dfu_pkg::ST_ERROR;
					nxt.status = dfu_pkg::SC_UNKNOWN;
					ok         = 1'b0;
				end else if (item.block_length == '0) begin
					nxt.proto  = dfu_pkg::ST_MANSYNC;
					nxt.status = dfu_pkg::SC_OK;
				end else begin
					nxt.addr          = target_addr;
					res.flash_address = target_addr;
					if (target_addr[SB_BITS-1:0] == '0) begin
						nxt.phase         = dfu_pkg::PH_ERASE;
						res.flash_command = dfu_pkg::CMD_ERASE;
					end else begin
						nxt.phase            = dfu_pkg::PH_PROGRAM;
						res.flash_command    = dfu_pkg::CMD_PROGRAM;
						res.flash_word_count = WORDS;
					end
					nxt.proto  = dfu_pkg::ST_DNSYNC;
					nxt.status = dfu_pkg::SC_OK;
				end
			end
			dfu_pkg::OP_GETSTATUS: begin
				if (cur.proto == dfu_pkg::ST_DNSYNC || cur.proto == dfu_pkg::ST_BUSY) begin
					if (cur.phase == dfu_pkg::PH_ERASE || cur.phase == dfu_pkg::PH_PROGRAM) begin
						if (!fs[dfu_pkg::FS_COMPLETE]) begin
							err = 1'b0;
						end else if (fs[dfu_pkg::FS_COLLISION]) begin
							err      = 1'b1;
							err_code = dfu_pkg::SC_UNKNOWN;
						end else if (fs[dfu_pkg::FS_ACCESS] || fs[dfu_pkg::FS_PROTECT]) begin
							err      = 1'b1;
							err_code = dfu_pkg::SC_ADDRESS;
						end else if (fs[dfu_pkg::FS_CMD_ERR]) begin
							err      = 1'b1;
							err_code = (cur.phase == dfu_pkg::PH_ERASE) ?
								dfu_pkg::SC_ERASE : dfu_pkg::SC_VERIFY;
						end else if (cur.phase == dfu_pkg::PH_ERASE) begin
							nxt.phase            = dfu_pkg::PH_PROGRAM;
							res.flash_command    = dfu_pkg::CMD_PROGRAM;
							res.flash_address    = cur.addr;
							res.flash_word_count = WORDS;
						end else begin
							nxt.phase = dfu_pkg::PH_IDLE;
						end
					end
					if (err) begin
						nxt.proto  = dfu_pkg::ST_ERROR;
						nxt.status = err_code;
						nxt.phase  = dfu_pkg::PH_IDLE;
					end else begin
						nxt.proto = (nxt.phase == dfu_pkg::PH_IDLE) ?
							dfu_pkg::ST_DNIDLE : dfu_pkg::ST_BUSY;
					end
				end else if (cur.proto == dfu_pkg::ST_MANSYNC) begin
					nxt.proto   = dfu_pkg::ST_MANIFEST;
					nxt.timeout = dfu_pkg::TIMEOUT_MANIFEST;
				end
			end
			dfu_pkg::OP_CLRSTATUS: begin
				if (cur.proto == dfu_pkg::ST_ERROR) begin
					nxt.proto  = dfu_pkg::ST_IDLE;
					nxt.status = dfu_pkg::SC_OK;
				end else begin
					nxt.proto  = dfu_pkg::ST_ERROR;
					nxt.status = dfu_pkg::SC_STALLED;
					ok         = 1'b0;
				end
			end
			default: begin
				nxt.proto  = dfu_pkg::ST_IDLE;
				nxt.status = dfu_pkg::SC_OK;
			end
		endcase

		res.accepted       = ok;
		res.request_status = nxt.status;
		res.poll_timeout   = nxt.timeout;
		res.protocol_state = dfu_pkg::proto_code(nxt.proto);
	end

endmodule

FILE: rtl/dfu_download_flash_sequencer.sv
// Top level of the DFU download sequencer: request register, target address,
// protocol state registers and result register around dfu_step.
// Depends on dfu_pkg, dfu_if (dfu_req_if, dfu_rsp_if) and dfu_step.
//
// channel   dir  handshake          payload
// req       in   req.valid/ready    op, block_number, block_length,
//                                   packet_offset, packet_length, flash_status
// rsp       out  rsp.valid/ready    accepted, request_status, poll_timeout,
//                                   protocol_state, flash_command,
//                                   flash_address, flash_word_count
// cfg       in   cfg_wr_en          cfg_wr_data (app_base_address)
//
// Requests pass the request and result registers, one per cycle while results
// are taken. The block address product is formed as the request is taken,
// the state update happens as the request moves into the result register.
// Reset clears the protocol state, the handshake valids and the base address.
// A stalled result holds the result register; the request register still
// takes one further request, then ready drops until the result is taken.
module dfu_download_flash_sequencer #(
	parameter int TRANSFER_BYTES = dfu_pkg::TRANSFER_BYTES_DEF,
	parameter int SECTOR_BYTES   = dfu_pkg::SECTOR_BYTES_DEF,
	parameter int WORD_BYTES     = dfu_pkg::WORD_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [dfu_pkg::ADDR_W-1:0] cfg_wr_data,
	dfu_req_if.sink                    req,
	dfu_rsp_if.source                  rsp
);

	localparam logic [15:0] WORDS = 16'(TRANSFER_BYTES / WORD_BYTES);

	logic [dfu_pkg::ADDR_W-1:0] base_q;
	dfu_pkg::state_t            state_q;
	dfu_pkg::state_t            state_nxt;
	dfu_pkg::result_t           res_nxt;

	logic                       valid_s1;
	dfu_pkg::item_t             item_s1;
	logic [dfu_pkg::ADDR_W-1:0] addr_s1;
	logic                       valid_s2;
	dfu_pkg::result_t           res_s2;

	logic                       take;
	logic                       adv;
	logic [dfu_pkg::ADDR_W-1:0] blk_addr;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;
	assign blk_addr  = base_q + dfu_pkg::ADDR_W'({8'b0, req.block_number} *
		dfu_pkg::ADDR_W'(TRANSFER_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op            <= dfu_pkg::op_t'(req.op);
			item_s1.block_length  <= req.block_length;
			item_s1.packet_offset <= req.packet_offset;
			item_s1.packet_length <= req.packet_length;
			item_s1.flash_status  <= req.flash_status;
			addr_s1               <= blk_addr;
		end
	end

	dfu_step #(
		.TRANSFER_BYTES (TRANSFER_BYTES),
		.SECTOR_BYTES   (SECTOR_BYTES),
		.WORD_BYTES     (WORD_BYTES)
	) u_step (
		.cur         (state_q),
		.item        (item_s1),
		.target_addr (addr_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.proto   <= dfu_pkg::ST_IDLE;
			state_q.status  <= dfu_pkg::SC_OK;
			state_q.timeout <= dfu_pkg::TIMEOUT_RESET;
			state_q.phase   <= dfu_pkg::PH_IDLE;
			state_q.addr    <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.accepted         = res_s2.accepted;
	assign rsp.request_status   = res_s2.request_status;
	assign rsp.poll_timeout     = res_s2.poll_timeout;
	assign rsp.protocol_state   = res_s2.protocol_state;
	assign rsp.flash_command    = res_s2.flash_command;
	assign rsp.flash_address    = res_s2.flash_address;
	assign rsp.flash_word_count = res_s2.flash_word_count;

	a_ready_only_on_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && !rsp.ready))
		else $error("request ready dropped without a full stall");

	a_program_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.flash_command == dfu_pkg::CMD_PROGRAM) |->
			(rsp.flash_word_count == WORDS))
		else $error("program command with wrong word count");

	a_no_command_no_address: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.flash_command == dfu_pkg::CMD_NONE) |->
			(rsp.flash_address == '0 && rsp.flash_word_count == '0))
		else $error("address or count given without a command");

	a_abort_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.op == dfu_pkg::OP_ABORT) |=>
			(state_q.proto == dfu_pkg::ST_IDLE && state_q.status == dfu_pkg::SC_OK))
		else $error("abort did not return to idle");

	a_error_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.op == dfu_pkg::OP_GETSTATUS && state_nxt.proto == dfu_pkg::ST_ERROR &&
			(state_q.proto == dfu_pkg::ST_DNSYNC || state_q.proto == dfu_pkg::ST_BUSY))
			|=> (state_q.phase == dfu_pkg::PH_IDLE))
		else $error("flash error left a phase pending");

endmodule

FILE: test/tb_dfu_download_flash_sequencer.sv
// Testbench for dfu_download_flash_sequencer: directed and random DFU requests
// on the request channel, each result checked against a cycle-free predictor.
// Depends on dfu_pkg and the dfu_req_if / dfu_rsp_if interfaces of the RTL.
`timescale 1ns / 100ps

module tb_dfu_download_flash_sequencer;

	localparam int XFER_BYTES   = dfu_pkg::TRANSFER_BYTES_DEF;
	localparam int SECTOR_BYTES = dfu_pkg::SECTOR_BYTES_DEF;
	localparam logic [15:0] PROGRAM_WORDS =
		16'(dfu_pkg::TRANSFER_BYTES_DEF / dfu_pkg::WORD_BYTES_DEF);
	localparam int HOLD_CYCLES  = 200;

	localparam logic [7:0] F_DONE = 8'(1 << dfu_pkg::FS_COMPLETE);
	localparam logic [7:0] F_COLL = 8'(1 << dfu_pkg::FS_COLLISION);
	localparam logic [7:0] F_ACC  = 8'(1 << dfu_pkg::FS_ACCESS);
	localparam logic [7:0] F_PROT = 8'(1 << dfu_pkg::FS_PROTECT);
	localparam logic [7:0] F_CMD  = 8'(1 << dfu_pkg::FS_CMD_ERR);

	typedef enum logic [1:0] {
		FP_IDLE    = 2'd0,
		FP_ERASE   = 2'd1,
		FP_PROGRAM = 2'd2
	} flash_phase_e;

	typedef struct packed {
		dfu_pkg::op_t op;
		logic [15:0]  block_number;
		logic [15:0]  block_length;
		logic [15:0]  packet_offset;
		logic [15:0]  packet_length;
		logic [7:0]   flash_status;
	} request_t;

	class flash_seq_tracker;
		dfu_pkg::proto_code_t proto    = dfu_pkg::PC_IDLE;
		dfu_pkg::status_t     status   = dfu_pkg::SC_OK;
		logic [9:0]           timeout  = dfu_pkg::TIMEOUT_RESET;
		flash_phase_e         phase    = FP_IDLE;
		logic [23:0]          cur_addr = '0;
		logic [23:0]          base     = '0;
		dfu_pkg::result_t     pending_results[$];
		int                   errors    = 0;
		int                   n_checked = 0;

		function void set_base(logic [23:0] v);
			base = v;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void raise_fault(dfu_pkg::status_t code);
			proto  = dfu_pkg::PC_ERROR;
			status = code;
		endfunction

		function void launch(dfu_pkg::cmd_t c, inout dfu_pkg::result_t r);
			r.flash_command    = c;
			r.flash_address    = cur_addr;
			r.flash_word_count = (c == dfu_pkg::CMD_PROGRAM) ? PROGRAM_WORDS : 16'd0;
		endfunction

		// true when the status byte is taken up by busy or an error
		function bit flash_blocked(logic [7:0] fs, dfu_pkg::status_t cmd_code);
			dfu_pkg::status_t code;
			if (!fs[dfu_pkg::FS_COMPLETE])
				return 1;
			if (fs[dfu_pkg::FS_COLLISION])
				code = dfu_pkg::SC_UNKNOWN;
			else if (fs[dfu_pkg::FS_ACCESS] || fs[dfu_pkg::FS_PROTECT])
				code = dfu_pkg::SC_ADDRESS;
			else if (fs[dfu_pkg::FS_CMD_ERR])
				code = cmd_code;
			else
				return 0;
			raise_fault(code);
			phase = FP_IDLE;
			return 1;
		endfunction

		function void note_request(request_t it);
			dfu_pkg::result_t r;
			bit               ok;
			logic [16:0]      pkt_end;
			r  = '0;
			ok = 1;
			case (it.op)
				dfu_pkg::OP_DNLOAD: begin
					pkt_end = it.packet_offset + it.packet_length;
					if (pkt_end > XFER_BYTES || pkt_end > it.block_length) begin
						raise_fault(dfu_pkg::SC_ADDRESS);
						ok = 0;
					end else if (pkt_end == it.block_length) begin
						if (proto != dfu_pkg::PC_IDLE && proto != dfu_pkg::PC_DNIDLE) begin
							raise_fault(dfu_pkg::SC_STALLED);
							ok = 0;
						end else if (!it.flash_status[dfu_pkg::FS_COMPLETE] ||
								phase != FP_IDLE) begin
							raise_fault(dfu_pkg::SC_UNKNOWN);
							ok = 0;
						end else if (it.block_length == 0) begin
							proto  = dfu_pkg::PC_MANSYNC;
							status = dfu_pkg::SC_OK;
						end else begin
							cur_addr = 24'(base + it.block_number * XFER_BYTES);
							if ((cur_addr % SECTOR_BYTES) == 0) begin
								phase = FP_ERASE;
								launch(dfu_pkg::CMD_ERASE, r);
							end else begin
								phase = FP_PROGRAM;
								launch(dfu_pkg::CMD_PROGRAM, r);
							end
							proto  = dfu_pkg::PC_DNSYNC;
							status = dfu_pkg::SC_OK;
						end
					end
				end
				dfu_pkg::OP_GETSTATUS: begin
					if (proto == dfu_pkg::PC_DNSYNC || proto == dfu_pkg::PC_BUSY) begin
						if (phase == FP_ERASE) begin
							if (!flash_blocked(it.flash_status, dfu_pkg::SC_ERASE)) begin
								phase = FP_PROGRAM;
								launch(dfu_pkg::CMD_PROGRAM, r);
							end
						end else if (phase == FP_PROGRAM) begin
							if (!flash_blocked(it.flash_status, dfu_pkg::SC_VERIFY))
								phase = FP_IDLE;
						end
						if (proto != dfu_pkg::PC_ERROR)
							proto = (phase == FP_IDLE) ? dfu_pkg::PC_DNIDLE : dfu_pkg::PC_BUSY;
					end else if (proto == dfu_pkg::PC_MANSYNC) begin
						proto   = dfu_pkg::PC_MANIFEST;
						timeout = dfu_pkg::TIMEOUT_MANIFEST;
					end
				end
				dfu_pkg::OP_CLRSTATUS: begin
					if (proto == dfu_pkg::PC_ERROR) begin
						proto  = dfu_pkg::PC_IDLE;
						status = dfu_pkg::SC_OK;
					end else begin
						raise_fault(dfu_pkg::SC_STALLED);
						ok = 0;
					end
				end
				default: begin
					proto  = dfu_pkg::PC_IDLE;
					status = dfu_pkg::SC_OK;
				end
			endcase
			r.accepted       = ok;
			r.request_status = status;
			r.poll_timeout   = timeout;
			r.protocol_state = proto;
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("ERROR at %0t, result %0d: %s", $time, n_checked, msg);
		endtask

		task cmp(string field, logic [23:0] got, logic [23:0] want);
			if (got !== want)
				report($sformatf("%s got %0h, expected %0h", field, got, want));
		endtask

		task check_result(dfu_pkg::result_t got);
			dfu_pkg::result_t want;
			n_checked++;
			if (pending_results.size() == 0) begin
				report("result with nothing outstanding");
				return;
			end
			want = pending_results.pop_front();
			cmp("accepted", got.accepted, want.accepted);
			cmp("request_status", got.request_status, want.request_status);
			cmp("poll_timeout", got.poll_timeout, want.poll_timeout);
			cmp("protocol_state", got.protocol_state, want.protocol_state);
			cmp("flash_command", got.flash_command, want.flash_command);
			cmp("flash_address", got.flash_address, want.flash_address);
			cmp("flash_word_count", got.flash_word_count, want.flash_word_count);
		endtask

		task finish_check();
			while (pending_results.size() != 0) begin
				report("expected result never arrived");
				void'(pending_results.pop_front());
			end
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [23:0]      cfg_wr_data;
	bit               no_idle  = 0;
	bit               hold_req = 0;
	int               n_items  = 0;
	dfu_pkg::result_t seen;

	flash_seq_tracker tracker = new;

	dfu_req_if req_ch();
	dfu_rsp_if rsp_ch();

	dfu_download_flash_sequencer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("dfu_download_flash_sequencer: mismatch");
		$finish;
	end

	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] rand8();
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] noise_len();
		return $urandom_range(0, 1) ? 16'($urandom_range(0, 1100)) : rand16();
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] poll_status(int n);
		int r;
		r = $urandom_range(0, 99);
		if (n >= 8 || r < 65)
			return F_DONE | (rand8() & 8'h0E);
		if (r < 85)
			return rand8() & ~F_DONE;
		return rand8() | F_DONE;
	endfunction

	function automatic request_t mk(dfu_pkg::op_t op, logic [15:0] blk, logic [15:0] blen,
			logic [15:0] off, logic [15:0] plen, logic [7:0] fs);
		request_t it;
		it.op            = op;
		it.block_number  = blk;
		it.block_length  = blen;
		it.packet_offset = off;
		it.packet_length = plen;
		it.flash_status  = fs;
		return it;
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen = {rsp_ch.accepted, rsp_ch.request_status, rsp_ch.poll_timeout,
				rsp_ch.protocol_state, rsp_ch.flash_command, rsp_ch.flash_address,
				rsp_ch.flash_word_count};
			tracker.check_result(seen);
		end
	end

	initial begin
		int g;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else if (no_idle) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				g = pick_gap();
				if (g > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	task automatic send(input request_t it);
		int g;
		g = pick_gap();
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.op            <= it.op;
		req_ch.block_number  <= it.block_number;
		req_ch.block_length  <= it.block_length;
		req_ch.packet_offset <= it.packet_offset;
		req_ch.packet_length <= it.packet_length;
		req_ch.flash_status  <= it.flash_status;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_request(it);
		n_items++;
	endtask

	task automatic write_base(input logic [23:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		tracker.set_base(v);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic settle_and_config(input logic [23:0] v);
		req_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_base(v);
	endtask

	task automatic drain_flash();
		int n;
		logic [15:0] b, off;
		n = 0;
		while (tracker.phase != FP_IDLE &&
				(tracker.proto == dfu_pkg::PC_DNSYNC || tracker.proto == dfu_pkg::PC_BUSY)) begin
			if ($urandom_range(0, 9) == 0) begin
				b   = 16'($urandom_range(2, XFER_BYTES));
				off = 16'($urandom_range(0, b - 2));
				send(mk(dfu_pkg::OP_DNLOAD, rand16(), b, off,
					16'($urandom_range(0, b - 1 - off)), rand8()));
			end else begin
				send(mk(dfu_pkg::OP_GETSTATUS, rand16(), rand16(), rand16(), rand16(),
					poll_status(n)));
			end
			n++;
		end
	endtask

	task automatic run_block();
		logic [15:0] blk, blen, off, plen;
		logic [7:0]  fs;
		int          npk, k, r;
		drain_flash();
		if (tracker.proto == dfu_pkg::PC_ERROR)
			send(mk(dfu_pkg::OP_CLRSTATUS, rand16(), rand16(), rand16(), rand16(), rand8()));
		else if (tracker.proto != dfu_pkg::PC_IDLE && tracker.proto != dfu_pkg::PC_DNIDLE)
			send(mk(dfu_pkg::OP_ABORT, rand16(), rand16(), rand16(), rand16(), rand8()));
		r    = $urandom_range(0, 99);
		blk  = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : rand16();
		blen = (r < 8) ? 16'd0 : (r < 30) ? 16'(XFER_BYTES) :
			16'($urandom_range(1, XFER_BYTES));
		npk  = (blen == 0) ? 1 : $urandom_range(1, 3);
		off  = '0;
		for (k = 0; k < npk; k++) begin
			if (k == npk - 1) begin
				plen = blen - off;
				if ($urandom_range(0, 19) == 0)
					plen++;
				fs = ($urandom_range(0, 9) == 0) ? rand8() : (F_DONE | (rand8() & 8'h7F));
			end else begin
				plen = 16'($urandom_range(0, blen - off));
				fs   = rand8();
			end
			send(mk(dfu_pkg::OP_DNLOAD, blk, blen, off, plen, fs));
			off += plen;
		end
		drain_flash();
		if (tracker.proto == dfu_pkg::PC_MANSYNC || $urandom_range(0, 3) == 0)
			send(mk(dfu_pkg::OP_GETSTATUS, rand16(), rand16(), rand16(), rand16(), rand8()));
	endtask

	task automatic run_random(input int count);
		int stop;
		stop = n_items + count;
		while (n_items < stop) begin
			drain_flash();
			if ($urandom_range(0, 3) == 0)
				send(mk(dfu_pkg::op_t'($urandom_range(0, 3)), rand16(), noise_len(),
					noise_len(), noise_len(), rand8()));
			else
				run_block();
		end
		drain_flash();
	endtask

	initial begin
		int w;
		arst_n               <= 1'b0;
		cfg_wr_en            <= 1'b0;
		cfg_wr_data          <= '0;
		req_ch.valid         <= 1'b0;
		req_ch.op            <= dfu_pkg::OP_DNLOAD;
		req_ch.block_number  <= '0;
		req_ch.block_length  <= '0;
		req_ch.packet_offset <= '0;
		req_ch.packet_length <= '0;
		req_ch.flash_status  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base(24'h000000);

		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd0, 16'd1024, 16'd0, 16'd512, F_DONE));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd0, 16'd1024, 16'd512, 16'd512, 8'hFF));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, 8'h7F));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, F_DONE));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, F_DONE | 8'h0E));
		send(mk(dfu_pkg::OP_DNLOAD, 16'hFFFF, 16'd1, 16'd0, 16'd1, F_DONE));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, F_DONE | F_COLL | F_CMD));
		send(mk(dfu_pkg::OP_CLRSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_CLRSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_ABORT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd2, 16'd64, 16'd0, 16'd64, F_DONE));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0,
			F_DONE | F_ACC | F_PROT | F_CMD));
		send(mk(dfu_pkg::OP_ABORT, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd4, 16'd8, 16'd0, 16'd8, F_DONE));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, F_DONE | F_CMD));
		send(mk(dfu_pkg::OP_CLRSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd1, 16'd4, 16'd0, 16'd4, F_DONE));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, F_DONE | F_CMD));
		send(mk(dfu_pkg::OP_CLRSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd3, 16'd16, 16'd0, 16'd16, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, F_DONE));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd0, 16'd1024, 16'd1024, 16'd0, F_DONE));
		send(mk(dfu_pkg::OP_ABORT, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd0, 16'd0, 16'd0, 16'd0, F_DONE));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd5, 16'd4, 16'd0, 16'd4, F_DONE));
		send(mk(dfu_pkg::OP_ABORT, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));

		settle_and_config(24'hFFFFFF);
		run_random(110);
		settle_and_config(24'h000C00);
		// hold the result side off while requests keep coming
		hold_req = 1;
		no_idle  = 1;
		run_random(30);
		no_idle = 0;
		run_random(80);
		settle_and_config(24'($urandom));
		no_idle = 1;
		run_random(40);
		no_idle = 0;
		run_random(80);
		settle_and_config(24'h000000);
		run_random(110);

		// abort mid-erase leaves the flash phase busy, so the next block is refused
		send(mk(dfu_pkg::OP_ABORT, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd6, 16'd32, 16'd0, 16'd32, F_DONE));
		send(mk(dfu_pkg::OP_ABORT, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		send(mk(dfu_pkg::OP_DNLOAD, 16'd7, 16'd32, 16'd0, 16'd32, F_DONE));
		send(mk(dfu_pkg::OP_GETSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, F_DONE));
		send(mk(dfu_pkg::OP_CLRSTATUS, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00));
		req_ch.valid <= 1'b0;

		for (w = 0; w < 20000 && tracker.pending() != 0; w++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		tracker.finish_check();
		if (tracker.errors == 0)
			$display("dfu_download_flash_sequencer: match");
		else
			$display("dfu_download_flash_sequencer: mismatch");
		$finish;
	end

endmodule
